/* rtl/tcpa_pkg.sv */
// Constants, codes and address helpers for the two-class pool allocator.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package tcpa_pkg;

	localparam int unsigned ADDR_W = 10;
	localparam int unsigned CMD_W = 2;
	localparam int unsigned ST_W = 2;

	localparam int unsigned SMALL_SLOTS = 8;
	localparam int unsigned BIG_SLOTS = 4;
	localparam int unsigned SMALL_CHUNK_BYTES = 24;
	localparam int unsigned BIG_CHUNK_BYTES = 192;
	localparam int unsigned HEADER_BYTES = 8;

	localparam int unsigned SMALL_BASE = 0;
	localparam int unsigned SMALL_SPAN = SMALL_SLOTS * SMALL_CHUNK_BYTES;
	localparam int unsigned SMALL_END = SMALL_BASE + SMALL_SPAN;
	localparam int unsigned BIG_BASE = SMALL_END;
	localparam int unsigned BIG_SPAN = BIG_SLOTS * BIG_CHUNK_BYTES;
	localparam int unsigned BIG_END = BIG_BASE + BIG_SPAN;

	localparam int unsigned SMALL_IDX_W = (SMALL_SLOTS > 1) ? $clog2(SMALL_SLOTS) : 1;
	localparam int unsigned BIG_IDX_W = (BIG_SLOTS > 1) ? $clog2(BIG_SLOTS) : 1;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CMD_W-1:0] cmd_t;
	typedef logic [ST_W-1:0] status_t;
	typedef logic [SMALL_IDX_W-1:0] small_idx_t;
	typedef logic [BIG_IDX_W-1:0] big_idx_t;

	localparam cmd_t CMD_ALLOC_SMALL = 2'd0;
	localparam cmd_t CMD_ALLOC_BIG = 2'd1;
	localparam cmd_t CMD_FREE = 2'd2;

	localparam status_t ST_DONE = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_IGNORED = 2'd2;

	// payload address of a slot, wrapped to the address width
	function automatic addr_t small_grant(input small_idx_t slot);
		logic [31:0] a;
		a = SMALL_BASE + 32'(slot) * SMALL_CHUNK_BYTES + HEADER_BYTES;
		return a[ADDR_W-1:0];
	endfunction

	function automatic addr_t big_grant(input big_idx_t slot);
		logic [31:0] a;
		a = BIG_BASE + 32'(slot) * BIG_CHUNK_BYTES + HEADER_BYTES;
		return a[ADDR_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/tcpa_req_if.sv */
// Request channel: command and address to free, valid/ready handshake.
// Depends on tcpa_pkg.
`default_nettype none

interface tcpa_req_if;
	logic valid;
	logic ready;
	tcpa_pkg::cmd_t cmd;
	tcpa_pkg::addr_t free_address;

	modport source (output valid, output cmd, output free_address, input ready);
	modport sink (input valid, input cmd, input free_address, output ready);
endinterface

`default_nettype wire

/* rtl/tcpa_rsp_if.sv */
// Response channel: granted address and status, valid/ready handshake.
// Depends on tcpa_pkg.
`default_nettype none

interface tcpa_rsp_if;
	logic valid;
	logic ready;
	tcpa_pkg::addr_t chunk_address;
	tcpa_pkg::status_t status;

	modport source (output valid, output chunk_address, output status, input ready);
	modport sink (input valid, input chunk_address, input status, output ready);
endinterface

`default_nettype wire

/* rtl/two_class_pool_allocator.sv */
// Two-class fixed-size pool allocator with LIFO free lists held in flops.
// Depends on tcpa_pkg, tcpa_req_if and tcpa_rsp_if.
//
//   channel  dir  word
//   req      in   cmd, free_address
//   rsp      out  chunk_address, status
//
// One word per cycle sustained while rsp.ready stays high; a request passes
// the input register, then the result register, before its response is valid.
// The list pop or push is done between the input and result registers,
// so the next word already sees the updated lists.
// Reset rebuilds both lists at once; no sweep after reset.
// A stalled response holds the result register, and the input register
// fills behind it before req.ready drops.
`default_nettype none

module two_class_pool_allocator (
	input wire logic clk,
	input wire logic arst_n,
	tcpa_req_if.sink req,
	tcpa_rsp_if.source rsp
);

	logic valid_s1;
	tcpa_pkg::cmd_t cmd_s1;
	tcpa_pkg::addr_t addr_s1;
	logic advance;

	logic small_hv_q;
	tcpa_pkg::small_idx_t small_head_q;
	logic [tcpa_pkg::SMALL_SLOTS-1:0] small_lv_q;
	tcpa_pkg::small_idx_t small_links_q [tcpa_pkg::SMALL_SLOTS];

	logic big_hv_q;
	tcpa_pkg::big_idx_t big_head_q;
	logic [tcpa_pkg::BIG_SLOTS-1:0] big_lv_q;
	tcpa_pkg::big_idx_t big_links_q [tcpa_pkg::BIG_SLOTS];

	logic rsp_valid_q;
	tcpa_pkg::addr_t chunk_q;
	tcpa_pkg::status_t status_q;

	logic pop_small, pop_big, push_small, push_big;
	tcpa_pkg::small_idx_t small_slot;
	tcpa_pkg::big_idx_t big_slot;
	tcpa_pkg::addr_t chunk_d;
	tcpa_pkg::status_t status_d;
	tcpa_pkg::addr_t c;
	logic [31:0] c_ext;
	logic small_hit, big_hit;

	assign advance = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			cmd_s1 <= req.cmd;
			addr_s1 <= req.free_address;
		end
	end

	// slot decode: one compare per slot start replaces the divide and modulo
	always_comb begin
		c = addr_s1 - tcpa_pkg::ADDR_W'(tcpa_pkg::HEADER_BYTES);
		c_ext = 32'(c);
		small_hit = 1'b0;
		small_slot = '0;
		for (int i = 0; i < int'(tcpa_pkg::SMALL_SLOTS); i++) begin
			if (c_ext == 32'(tcpa_pkg::SMALL_BASE + i * tcpa_pkg::SMALL_CHUNK_BYTES)) begin
				small_hit = 1'b1;
				small_slot = tcpa_pkg::SMALL_IDX_W'(i);
			end
		end
		big_hit = 1'b0;
		big_slot = '0;
		for (int j = 0; j < int'(tcpa_pkg::BIG_SLOTS); j++) begin
			if (c_ext == 32'(tcpa_pkg::BIG_BASE + j * tcpa_pkg::BIG_CHUNK_BYTES)) begin
				big_hit = 1'b1;
				big_slot = tcpa_pkg::BIG_IDX_W'(j);
			end
		end
	end

	always_comb begin
		pop_small = 1'b0;
		pop_big = 1'b0;
		push_small = 1'b0;
		push_big = 1'b0;
		chunk_d = '0;
		status_d = tcpa_pkg::ST_DONE;
		unique case (cmd_s1)
			tcpa_pkg::CMD_ALLOC_SMALL: begin
				if (small_hv_q) begin
					pop_small = 1'b1;
					chunk_d = tcpa_pkg::small_grant(small_head_q);
				end else begin
					status_d = tcpa_pkg::ST_EMPTY;
				end
			end
			tcpa_pkg::CMD_ALLOC_BIG: begin
				if (big_hv_q) begin
					pop_big = 1'b1;
					chunk_d = tcpa_pkg::big_grant(big_head_q);
				end else begin
					status_d = tcpa_pkg::ST_EMPTY;
				end
			end
			tcpa_pkg::CMD_FREE: begin
				status_d = tcpa_pkg::ST_IGNORED;
				if (32'(addr_s1) >= tcpa_pkg::HEADER_BYTES) begin
					// ranges are disjoint, so the hits already imply the range
					if (small_hit) begin
						push_small = 1'b1;
						status_d = tcpa_pkg::ST_DONE;
					end else if (big_hit) begin
						push_big = 1'b1;
						status_d = tcpa_pkg::ST_DONE;
					end
				end
			end
			default: begin
				status_d = tcpa_pkg::ST_IGNORED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_hv_q <= 1'b1;
			small_head_q <= tcpa_pkg::SMALL_IDX_W'(tcpa_pkg::SMALL_SLOTS - 1);
			for (int i = 0; i < int'(tcpa_pkg::SMALL_SLOTS); i++) begin
				small_lv_q[i] <= (i != 0);
				small_links_q[i] <= (i != 0) ? tcpa_pkg::SMALL_IDX_W'(i - 1) : '0;
			end
			big_hv_q <= 1'b1;
			big_head_q <= tcpa_pkg::BIG_IDX_W'(tcpa_pkg::BIG_SLOTS - 1);
			for (int j = 0; j < int'(tcpa_pkg::BIG_SLOTS); j++) begin
				big_lv_q[j] <= (j != 0);
				big_links_q[j] <= (j != 0) ? tcpa_pkg::BIG_IDX_W'(j - 1) : '0;
			end
		end else if (advance) begin
			if (pop_small) begin
				small_hv_q <= small_lv_q[small_head_q];
				small_head_q <= small_links_q[small_head_q];
			end
			if (push_small) begin
				small_lv_q[small_slot] <= small_hv_q;
				small_links_q[small_slot] <= small_head_q;
				small_hv_q <= 1'b1;
				small_head_q <= small_slot;
			end
			if (pop_big) begin
				big_hv_q <= big_lv_q[big_head_q];
				big_head_q <= big_links_q[big_head_q];
			end
			if (push_big) begin
				big_lv_q[big_slot] <= big_hv_q;
				big_links_q[big_slot] <= big_head_q;
				big_hv_q <= 1'b1;
				big_head_q <= big_slot;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			chunk_q <= chunk_d;
			status_q <= status_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.chunk_address = chunk_q;
	assign rsp.status = status_q;

	a_no_addr_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != tcpa_pkg::ST_DONE |-> rsp.chunk_address == '0)
		else $error("nonzero address on a failed request");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(cmd_s1) && $stable(addr_s1))
		else $error("input register lost a stalled word");

	a_small_empty_by_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(small_hv_q) |-> $past(advance && pop_small))
		else $error("small list emptied without an allocation");

	a_big_empty_by_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(big_hv_q) |-> $past(advance && pop_big))
		else $error("big list emptied without an allocation");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking bench for two_class_pool_allocator: directed rows, then random
// allocate/free traffic, with a free-list mirror that works out every reply.
// Depends on tcpa_pkg, tcpa_req_if, tcpa_rsp_if and the allocator RTL.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcpa_pkg::*;

	localparam cmd_t CMD_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 1900;

	typedef struct packed {
		addr_t chunk_address;
		status_t status;
	} pool_reply_t;

	typedef struct packed {
		cmd_t cmd;
		addr_t addr;
		logic typed;
		addr_t want_addr;
		status_t want_status;
	} plan_row_t;

	typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_ONE_IN_THREE, SINK_HEAVY} sink_mode_t;

	// rows with typed replies are read straight off the address map
	plan_row_t plan [25] = '{
		'{CMD_ALLOC_SMALL, 10'd0, 1'b1, 10'd176, ST_DONE},
		'{CMD_ALLOC_BIG, 10'd1023, 1'b1, 10'd776, ST_DONE},
		'{CMD_FREE, 10'd0, 1'b1, 10'd0, ST_IGNORED},
		'{CMD_FREE, 10'd7, 1'b1, 10'd0, ST_IGNORED},
		'{CMD_FREE, 10'd1023, 1'b1, 10'd0, ST_IGNORED},
		'{CMD_FREE, 10'd968, 1'b1, 10'd0, ST_IGNORED},
		'{CMD_FREE, 10'd9, 1'b1, 10'd0, ST_IGNORED},
		'{CMD_FREE, 10'd199, 1'b1, 10'd0, ST_IGNORED},
		'{CMD_FREE, 10'd201, 1'b1, 10'd0, ST_IGNORED},
		'{CMD_UNUSED, 10'd1023, 1'b1, 10'd0, ST_IGNORED},
		'{CMD_FREE, 10'd176, 1'b1, 10'd0, ST_DONE},
		'{CMD_ALLOC_SMALL, 10'd512, 1'b0, 10'd0, ST_DONE},
		'{CMD_ALLOC_BIG, 10'd0, 1'b0, 10'd0, ST_DONE},
		'{CMD_ALLOC_BIG, 10'd0, 1'b0, 10'd0, ST_DONE},
		'{CMD_ALLOC_BIG, 10'd0, 1'b0, 10'd0, ST_DONE},
		'{CMD_ALLOC_BIG, 10'd0, 1'b1, 10'd0, ST_EMPTY},
		'{CMD_ALLOC_BIG, 10'd1023, 1'b1, 10'd0, ST_EMPTY},
		'{CMD_FREE, 10'd392, 1'b0, 10'd0, ST_DONE},
		'{CMD_ALLOC_BIG, 10'd0, 1'b0, 10'd0, ST_DONE},
		// big slot 0 freed twice: its list loops on itself from here on
		'{CMD_FREE, 10'd200, 1'b0, 10'd0, ST_DONE},
		'{CMD_FREE, 10'd200, 1'b0, 10'd0, ST_DONE},
		'{CMD_ALLOC_BIG, 10'd0, 1'b0, 10'd0, ST_DONE},
		'{CMD_ALLOC_BIG, 10'd0, 1'b0, 10'd0, ST_DONE},
		'{CMD_FREE, 10'd776, 1'b0, 10'd0, ST_DONE},
		'{CMD_ALLOC_BIG, 10'd0, 1'b0, 10'd0, ST_DONE}
	};

	logic clk;
	logic arst_n;

	tcpa_req_if req_ch ();
	tcpa_rsp_if rsp_ch ();

	two_class_pool_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// free-list mirror
	logic small_head_ok;
	small_idx_t small_head;
	logic small_link_ok [SMALL_SLOTS];
	small_idx_t small_link [SMALL_SLOTS];
	logic big_head_ok;
	big_idx_t big_head;
	logic big_link_ok [BIG_SLOTS];
	big_idx_t big_link [BIG_SLOTS];

	pool_reply_t pool_replies_due [$];
	addr_t live_addrs [$];

	int words_sent = 0;
	int replies_seen = 0;
	int errors = 0;
	int granted = 0;
	int exhausted = 0;
	int ignored = 0;
	int burst_left = 0;
	bit rx_holding = 1'b0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic pool_reply_t pool_reply_for(input cmd_t cmd, input addr_t addr);
		pool_reply_t r;
		int unsigned c;
		int unsigned off;
		small_idx_t ss;
		big_idx_t bs;
		r.chunk_address = '0;
		r.status = ST_DONE;
		case (cmd)
			CMD_ALLOC_SMALL: begin
				if (small_head_ok) begin
					ss = small_head;
					small_head_ok = small_link_ok[ss];
					small_head = small_link[ss];
					c = SMALL_BASE + int'(ss) * SMALL_CHUNK_BYTES + HEADER_BYTES;
					r.chunk_address = addr_t'(c);
				end else begin
					r.status = ST_EMPTY;
				end
			end
			CMD_ALLOC_BIG: begin
				if (big_head_ok) begin
					bs = big_head;
					big_head_ok = big_link_ok[bs];
					big_head = big_link[bs];
					c = BIG_BASE + int'(bs) * BIG_CHUNK_BYTES + HEADER_BYTES;
					r.chunk_address = addr_t'(c);
				end else begin
					r.status = ST_EMPTY;
				end
			end
			CMD_FREE: begin
				r.status = ST_IGNORED;
				if (addr >= HEADER_BYTES) begin
					c = int'(addr) - HEADER_BYTES;
					if (c >= SMALL_BASE && c < SMALL_END) begin
						off = c - SMALL_BASE;
						if (off % SMALL_CHUNK_BYTES == 0) begin
							ss = small_idx_t'(off / SMALL_CHUNK_BYTES);
							small_link_ok[ss] = small_head_ok;
							small_link[ss] = small_head;
							small_head_ok = 1'b1;
							small_head = ss;
							r.status = ST_DONE;
						end
					end else if (c >= BIG_BASE && c < BIG_END) begin
						off = c - BIG_BASE;
						if (off % BIG_CHUNK_BYTES == 0) begin
							bs = big_idx_t'(off / BIG_CHUNK_BYTES);
							big_link_ok[bs] = big_head_ok;
							big_link[bs] = big_head;
							big_head_ok = 1'b1;
							big_head = bs;
							r.status = ST_DONE;
						end
					end
				end
			end
			default: r.status = ST_IGNORED;
		endcase
		return r;
	endfunction

	task automatic rest(input int n);
		repeat (n) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
	endtask

	// bursts of random length; no gaps while the receiver is holding off
	task automatic pace();
		if (burst_left == 0) begin
			if (!rx_holding)
				rest(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6));
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
	endtask

	task automatic send_word(input cmd_t c, input addr_t a, input logic typed,
			input pool_reply_t typed_reply);
		pool_reply_t r;
		int hits [$];
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.cmd <= c;
		req_ch.free_address <= a;
		do @(posedge clk); while (!req_ch.ready);
		words_sent++;
		r = pool_reply_for(c, a);
		pool_replies_due.push_back(typed ? typed_reply : r);
		if ((c == CMD_ALLOC_SMALL || c == CMD_ALLOC_BIG) && r.status == ST_DONE)
			live_addrs.push_back(r.chunk_address);
		if (c == CMD_FREE && r.status == ST_DONE) begin
			hits = live_addrs.find_first_index(x) with (x == a);
			if (hits.size() != 0)
				live_addrs.delete(hits[0]);
		end
	endtask

	task automatic drain();
		rest(1);
		while (pool_replies_due.size() != 0)
			@(posedge clk);
	endtask

	// sender
	initial begin
		cmd_t c;
		addr_t a;
		int r;
		int phase_left;
		bit filling;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_ALLOC_SMALL;
		req_ch.free_address = '0;
		small_head_ok = 1'b1;
		small_head = small_idx_t'(SMALL_SLOTS - 1);
		for (int i = 0; i < SMALL_SLOTS; i++) begin
			small_link_ok[i] = (i != 0);
			small_link[i] = small_idx_t'((i != 0) ? i - 1 : 0);
		end
		big_head_ok = 1'b1;
		big_head = big_idx_t'(BIG_SLOTS - 1);
		for (int i = 0; i < BIG_SLOTS; i++) begin
			big_link_ok[i] = (i != 0);
			big_link[i] = big_idx_t'((i != 0) ? i - 1 : 0);
		end
		phase_left = 0;
		filling = 1'b0;
		wait (arst_n === 1'b1);

		foreach (plan[i]) begin
			pace();
			send_word(plan[i].cmd, plan[i].addr, plan[i].typed,
				{plan[i].want_addr, plan[i].want_status});
		end
		drain();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == RANDOM_WORDS / 2)
				drain();
			// alternate between filling the pools and handing chunks back
			if (phase_left == 0) begin
				filling = !filling;
				phase_left = $urandom_range(20, 90);
			end
			phase_left--;
			r = $urandom_range(99);
			a = addr_t'($urandom);
			if (r < (filling ? 45 : 15)) begin
				c = CMD_ALLOC_SMALL;
			end else if (r < (filling ? 70 : 25)) begin
				c = CMD_ALLOC_BIG;
			end else if (r < 90 && live_addrs.size() != 0) begin
				c = CMD_FREE;
				a = live_addrs[$urandom_range(live_addrs.size() - 1)];
			end else if (r < 97) begin
				c = CMD_FREE;
				// keep stray frees off small slot starts so that list stays sound
				if (a >= HEADER_BYTES && int'(a) - HEADER_BYTES < SMALL_END
						&& (int'(a) - HEADER_BYTES) % SMALL_CHUNK_BYTES == 0)
					a[0] = ~a[0];
			end else begin
				c = CMD_UNUSED;
			end
			pace();
			send_word(c, a, 1'b0, '0);
		end
		drain();
		repeat (8) @(posedge clk);

		$display("%0d words sent (%0d directed), %0d replies checked",
			words_sent, $size(plan), replies_seen);
		$display("replies: %0d done, %0d pool empty, %0d ignored; %0d mismatches",
			granted, exhausted, ignored, errors);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// receiver
	initial begin
		int left;
		int hold_at;
		sink_mode_t mode;
		rsp_ch.ready = 1'b0;
		left = 0;
		hold_at = 300;
		mode = SINK_OPEN;
		forever begin
			@(negedge clk);
			if (replies_seen >= hold_at) begin
				// long hold-off so the block backs up into its input
				rx_holding = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (60) @(negedge clk);
				rx_holding = 1'b0;
				hold_at += 700;
			end else begin
				if (left == 0) begin
					mode = sink_mode_t'($urandom_range(3));
					left = $urandom_range(16, 120);
				end
				left--;
				case (mode)
					SINK_OPEN: rsp_ch.ready <= 1'b1;
					SINK_LIGHT: rsp_ch.ready <= ($urandom_range(9) < 7);
					SINK_ONE_IN_THREE: rsp_ch.ready <= ((left % 3) == 0);
					default: rsp_ch.ready <= ($urandom_range(9) < 3);
				endcase
			end
		end
	end

	// reply checker
	always @(posedge clk) begin
		pool_reply_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			replies_seen++;
			case (rsp_ch.status)
				ST_DONE: granted++;
				ST_EMPTY: exhausted++;
				default: ignored++;
			endcase
			if (pool_replies_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: reply with none due: addr %0d status %0d",
						$realtime, rsp_ch.chunk_address, rsp_ch.status);
			end else begin
				want = pool_replies_due.pop_front();
				if (rsp_ch.chunk_address !== want.chunk_address
						|| rsp_ch.status !== want.status) begin
					errors++;
					if (errors <= 10)
						$display("%0t: reply %0d want addr %0d status %0d, got addr %0d status %0d",
							$realtime, replies_seen, want.chunk_address, want.status,
							rsp_ch.chunk_address, rsp_ch.status);
				end
			end
		end
	end

endmodule
